@@ rtl/preemptive_priority_scheduler_defines.svh @@
// assertion macros for the preemptive priority scheduler
`ifndef PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH
`define PREEMPTIVE_PRIORITY_SCHEDULER_DEFINES_SVH

// same-cycle implication
`define PPS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/pps_pkg.sv @@
// ----------------------------------------------------------------------------
// pps_pkg
// shared types and constants of the preemptive priority scheduler
// ----------------------------------------------------------------------------
`default_nettype none

package pps_pkg;

    localparam int ID_W    = 16;
    localparam int TS_W    = 24;
    localparam int BURST_W = 16;
    localparam int PRIO_W  = 8;
    localparam int END_W   = 25;
    localparam int ENTRY_W = 40;

    localparam logic KIND_ARRIVAL  = 1'b0;
    localparam logic KIND_COMPLETE = 1'b1;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_EXEC  = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_DRAIN = 7'b0001000,
        S_ARB   = 7'b0010000,
        S_ARL   = 7'b0100000,
        S_FIN   = 7'b1000000
    } state_t;

    typedef struct packed {
        logic clear;
        logic cmp_en;
    } scan_ctrl_t;

endpackage

`default_nettype wire

@@ rtl/preemptive_priority_scheduler.sv @@
// sequence: an arrival, or a completion with an empty queue, goes from the exec state
// to the fin state and the output register; a completion with queued entries passes
// exec, scan, drain, arb, arl and fin, with one queue ram read per entry in the scan
// throughput: one beat in flight; the next beat is taken once the result is registered
// reset: asynchronous, cpu idle and empty queue; queue rams are not cleared
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler
// preemptive priority scheduler with a ram-backed ready queue
// ----------------------------------------------------------------------------
`default_nettype none

`include "preemptive_priority_scheduler_defines.svh"

module preemptive_priority_scheduler
    import pps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               kind,
    input  wire logic [ID_W-1:0]    proc_ident,
    input  wire logic [TS_W-1:0]    proc_arrival,
    input  wire logic [BURST_W-1:0] proc_burst,
    input  wire logic [PRIO_W-1:0]  proc_priority,
    input  wire logic [TS_W-1:0]    now,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic                    cpu_idle,
    output logic [ID_W-1:0]         run_ident,
    output logic [TS_W-1:0]         run_arrival,
    output logic [BURST_W-1:0]      run_total,
    output logic [BURST_W-1:0]      run_remaining,
    output logic [PRIO_W-1:0]       run_priority,
    output logic [TS_W-1:0]         run_start,
    output logic [END_W-1:0]        run_end,
    output logic                    rejected,
    output logic [4:0]              waiting_count
);

    localparam int IDX_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    state_t state_reg, state_next;

    // captured beat
    logic               kind_reg;
    logic [ID_W-1:0]    id_reg;
    logic [TS_W-1:0]    arr_reg;
    logic [BURST_W-1:0] burst_reg;
    logic [PRIO_W-1:0]  prio_reg;
    logic [TS_W-1:0]    now_reg;

    // running process
    logic               rv_reg, rv_next;
    logic [ID_W-1:0]    rid_reg, rid_next;
    logic [TS_W-1:0]    rarr_reg, rarr_next;
    logic [BURST_W-1:0] rtot_reg, rtot_next;
    logic [BURST_W-1:0] rrem_reg, rrem_next;
    logic [PRIO_W-1:0]  rprio_reg, rprio_next;
    logic [TS_W-1:0]    rstart_reg, rstart_next;
    logic [END_W-1:0]   rend_reg, rend_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic               rej_reg, rej_next;

    logic [IDX_W-1:0]   scan_addr_reg, scan_addr_next;
    logic [IDX_W-1:0]   pend_idx_reg;
    logic               pend_reg, pend_next;
    logic [ENTRY_W-1:0] last_ipb_reg;
    logic [ENTRY_W-1:0] ar_best_reg;

    // output register
    logic               ov_reg, ov_next;
    logic               o_idle_reg;
    logic [ID_W-1:0]    o_id_reg;
    logic [TS_W-1:0]    o_arr_reg;
    logic [BURST_W-1:0] o_tot_reg;
    logic [BURST_W-1:0] o_rem_reg;
    logic [PRIO_W-1:0]  o_prio_reg;
    logic [TS_W-1:0]    o_start_reg;
    logic [END_W-1:0]   o_end_reg;
    logic               o_rej_reg;
    logic [4:0]         o_cnt_reg;

    // queue rams
    logic               ipb_we, ar_we;
    logic [IDX_W-1:0]   ipb_waddr, ar_waddr, ar_raddr;
    logic [ENTRY_W-1:0] ipb_wdata, ar_wdata, ipb_rdata, ar_rdata;

    scan_ctrl_t         scan_ctrl;
    logic [IDX_W-1:0]   best_idx_next, best_idx;
    logic [ENTRY_W-1:0] best_data;

    logic               in_take, out_free, full;
    logic [CNT_W-1:0]   cnt_m1;
    logic [IDX_W-1:0]   last_idx;
    logic [END_W-1:0]   now_ext, diff;
    logic [BURST_W-1:0] preempt_rem;
    logic [CNT_W+4:0]   cnt_wide;

    assign in_stall = (state_reg != S_IDLE);
    assign in_take  = in_valid && !in_stall;
    assign out_free = !ov_reg || !out_stall;
    assign full     = (count_reg >= CNT_W'(QUEUE_DEPTH));
    assign cnt_m1   = count_reg - 1'b1;
    assign last_idx = cnt_m1[IDX_W-1:0];
    assign now_ext  = {1'b0, now_reg};
    assign diff     = rend_reg - now_ext;
    assign cnt_wide = (CNT_W + 5)'(count_reg);

    always_comb
    begin
        if (rend_reg <= now_ext)
        begin
            preempt_rem = '0;
        end
        else if (diff[END_W-1:BURST_W] != '0)
        begin
            preempt_rem = '1;
        end
        else
        begin
            preempt_rem = diff[BURST_W-1:0];
        end
    end

    assign scan_ctrl.clear  = (state_reg == S_EXEC);
    assign scan_ctrl.cmp_en = pend_reg && ((state_reg == S_SCAN) || (state_reg == S_DRAIN));
    assign ar_raddr         = (state_reg == S_DRAIN) ? best_idx_next : last_idx;

    always_comb
    begin
        state_next     = state_reg;
        rv_next        = rv_reg;
        rid_next       = rid_reg;
        rarr_next      = rarr_reg;
        rtot_next      = rtot_reg;
        rrem_next      = rrem_reg;
        rprio_next     = rprio_reg;
        rstart_next    = rstart_reg;
        rend_next      = rend_reg;
        count_next     = count_reg;
        rej_next       = rej_reg;
        scan_addr_next = scan_addr_reg;
        pend_next      = pend_reg;
        ov_next        = ov_reg && out_stall;
        ipb_we         = 1'b0;
        ipb_waddr      = count_reg[IDX_W-1:0];
        ipb_wdata      = {id_reg, prio_reg, burst_reg};
        ar_we          = 1'b0;
        ar_waddr       = count_reg[IDX_W-1:0];
        ar_wdata       = {arr_reg, burst_reg};

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_take)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                rej_next   = 1'b0;
                state_next = S_FIN;
                if (kind_reg == KIND_ARRIVAL)
                begin
                    if (!rv_reg)
                    begin
                        rv_next     = 1'b1;
                        rid_next    = id_reg;
                        rarr_next   = arr_reg;
                        rtot_next   = burst_reg;
                        rrem_next   = burst_reg;
                        rprio_next  = prio_reg;
                        rstart_next = now_reg;
                        rend_next   = now_ext + END_W'(burst_reg);
                    end
                    else if (full)
                    begin
                        rej_next = 1'b1;
                    end
                    else if (prio_reg >= rprio_reg)
                    begin
                        ipb_we     = 1'b1;
                        ar_we      = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    else
                    begin
                        ipb_we      = 1'b1;
                        ipb_wdata   = {rid_reg, rprio_reg, rtot_reg};
                        ar_we       = 1'b1;
                        ar_wdata    = {rarr_reg, preempt_rem};
                        count_next  = count_reg + 1'b1;
                        rid_next    = id_reg;
                        rarr_next   = arr_reg;
                        rtot_next   = burst_reg;
                        rrem_next   = burst_reg;
                        rprio_next  = prio_reg;
                        rstart_next = now_reg;
                        rend_next   = now_ext + END_W'(burst_reg);
                    end
                end
                else if (count_reg == '0)
                begin
                    rv_next     = 1'b0;
                    rid_next    = '0;
                    rarr_next   = '0;
                    rtot_next   = '0;
                    rrem_next   = '0;
                    rprio_next  = '0;
                    rstart_next = '0;
                    rend_next   = '0;
                end
                else
                begin
                    scan_addr_next = '0;
                    pend_next      = 1'b0;
                    state_next     = S_SCAN;
                end
            end
            S_SCAN:
            begin
                pend_next = 1'b1;
                if (scan_addr_reg == last_idx)
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    scan_addr_next = scan_addr_reg + 1'b1;
                end
            end
            S_DRAIN:
            begin
                state_next = S_ARB;
            end
            S_ARB:
            begin
                ipb_we     = 1'b1;
                ipb_waddr  = best_idx;
                ipb_wdata  = last_ipb_reg;
                state_next = S_ARL;
            end
            S_ARL:
            begin
                ar_we       = 1'b1;
                ar_waddr    = best_idx;
                ar_wdata    = ar_rdata;
                count_next  = cnt_m1;
                rv_next     = 1'b1;
                rid_next    = best_data[ENTRY_W-1 -: ID_W];
                rprio_next  = best_data[BURST_W +: PRIO_W];
                rtot_next   = best_data[BURST_W-1:0];
                rarr_next   = ar_best_reg[ENTRY_W-1 -: TS_W];
                rrem_next   = ar_best_reg[BURST_W-1:0];
                rstart_next = now_reg;
                rend_next   = now_ext + END_W'(ar_best_reg[BURST_W-1:0]);
                state_next  = S_FIN;
            end
            S_FIN:
            begin
                if (out_free)
                begin
                    ov_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            rv_reg     <= 1'b0;
            rid_reg    <= '0;
            rarr_reg   <= '0;
            rtot_reg   <= '0;
            rrem_reg   <= '0;
            rprio_reg  <= '0;
            rstart_reg <= '0;
            rend_reg   <= '0;
            count_reg  <= '0;
            rej_reg    <= 1'b0;
            pend_reg   <= 1'b0;
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rv_reg     <= rv_next;
            rid_reg    <= rid_next;
            rarr_reg   <= rarr_next;
            rtot_reg   <= rtot_next;
            rrem_reg   <= rrem_next;
            rprio_reg  <= rprio_next;
            rstart_reg <= rstart_next;
            rend_reg   <= rend_next;
            count_reg  <= count_next;
            rej_reg    <= rej_next;
            pend_reg   <= pend_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg  <= kind;
            id_reg    <= proc_ident;
            arr_reg   <= proc_arrival;
            burst_reg <= proc_burst;
            prio_reg  <= proc_priority;
            now_reg   <= now;
        end
        scan_addr_reg <= scan_addr_next;
        if (state_reg == S_SCAN)
        begin
            pend_idx_reg <= scan_addr_reg;
        end
        if (state_reg == S_DRAIN)
        begin
            last_ipb_reg <= ipb_rdata;
        end
        if (state_reg == S_ARB)
        begin
            ar_best_reg <= ar_rdata;
        end
        if ((state_reg == S_FIN) && out_free)
        begin
            o_idle_reg  <= !rv_reg;
            o_id_reg    <= rid_reg;
            o_arr_reg   <= rarr_reg;
            o_tot_reg   <= rtot_reg;
            o_rem_reg   <= rrem_reg;
            o_prio_reg  <= rprio_reg;
            o_start_reg <= rstart_reg;
            o_end_reg   <= rend_reg;
            o_rej_reg   <= rej_reg;
            o_cnt_reg   <= cnt_wide[4:0];
        end
    end

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ipb_ram (
        .clk     (clk),
        .wr_en   (ipb_we),
        .wr_addr (ipb_waddr),
        .wr_data (ipb_wdata),
        .rd_addr (scan_addr_reg),
        .rd_data (ipb_rdata)
    );

    pps_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ar_ram (
        .clk     (clk),
        .wr_en   (ar_we),
        .wr_addr (ar_waddr),
        .wr_data (ar_wdata),
        .rd_addr (ar_raddr),
        .rd_data (ar_rdata)
    );

    pps_scan #(
        .IDX_W (IDX_W)
    ) u_scan (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (scan_ctrl),
        .idx           (pend_idx_reg),
        .data          (ipb_rdata),
        .best_idx_next (best_idx_next),
        .best_idx      (best_idx),
        .best_data     (best_data)
    );

    assign out_valid     = ov_reg;
    assign cpu_idle      = o_idle_reg;
    assign run_ident     = o_id_reg;
    assign run_arrival   = o_arr_reg;
    assign run_total     = o_tot_reg;
    assign run_remaining = o_rem_reg;
    assign run_priority  = o_prio_reg;
    assign run_start     = o_start_reg;
    assign run_end       = o_end_reg;
    assign rejected      = o_rej_reg;
    assign waiting_count = o_cnt_reg;

    `PPS_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(QUEUE_DEPTH),
        "queue count beyond depth")
    `PPS_ASSERT_NOW(a_reject_busy, out_valid && rejected, !cpu_idle,
        "rejection reported with idle cpu")
    `PPS_ASSERT_NOW(a_idle_clear, out_valid && cpu_idle, (run_ident == '0) && (run_end == '0),
        "idle result carries running fields")
    `PPS_ASSERT_NEXT(a_scan_count, state_reg == S_SCAN, $stable(count_reg),
        "queue count moved during scan")

endmodule

`default_nettype wire

@@ rtl/pps_ram.sv @@
// ----------------------------------------------------------------------------
// pps_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module pps_ram #(
    parameter int WIDTH = 40,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

@@ rtl/pps_scan.sv @@
// ----------------------------------------------------------------------------
// pps_scan
// running minimum over queue entries, first index wins on ties
// ----------------------------------------------------------------------------
`default_nettype none

module pps_scan
    import pps_pkg::*;
#(
    parameter int IDX_W = 4
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire scan_ctrl_t             ctrl,
    input  wire logic [IDX_W-1:0]       idx,
    input  wire logic [ENTRY_W-1:0]     data,
    output logic      [IDX_W-1:0]       best_idx_next,
    output logic      [IDX_W-1:0]       best_idx,
    output logic      [ENTRY_W-1:0]     best_data
);

    logic                have_reg;
    logic                have_next;
    logic [IDX_W-1:0]    best_idx_reg;
    logic [ENTRY_W-1:0]  best_data_reg;
    logic [ENTRY_W-1:0]  best_data_next;
    logic [PRIO_W-1:0]   cand_prio;
    logic [PRIO_W-1:0]   best_prio;
    logic                take;

    assign cand_prio = data[BURST_W +: PRIO_W];
    assign best_prio = best_data_reg[BURST_W +: PRIO_W];
    assign take      = ctrl.cmp_en && (!have_reg || (cand_prio < best_prio));

    always_comb
    begin
        have_next      = have_reg;
        best_idx_next  = best_idx_reg;
        best_data_next = best_data_reg;
        if (ctrl.clear)
        begin
            have_next = 1'b0;
        end
        else if (take)
        begin
            have_next      = 1'b1;
            best_idx_next  = idx;
            best_data_next = data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            have_reg <= 1'b0;
        end
        else
        begin
            have_reg <= have_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg  <= best_idx_next;
        best_data_reg <= best_data_next;
    end

    assign best_idx  = best_idx_reg;
    assign best_data = best_data_reg;

endmodule

`default_nettype wire

@@ tb/sv/tb_preemptive_priority_scheduler.sv @@
// ----------------------------------------------------------------------------
// tb_preemptive_priority_scheduler
// self-checking bench for the preemptive priority scheduler: directed corner
// beats, then random arrival and completion traffic with bursty input and a
// stalling receiver, each result compared against a behavioral scheduler
// ----------------------------------------------------------------------------
module tb_preemptive_priority_scheduler;

    timeunit 1ns;
    timeprecision 1ps;

    import pps_pkg::*;

    localparam int QUEUE_SLOTS   = 16;
    localparam int RANDOM_BEATS  = 700;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;
    localparam int LIMIT_CYCLES  = 600000;

    typedef struct packed {
        logic                kind;
        logic [ID_W-1:0]     ident;
        logic [TS_W-1:0]     arrival;
        logic [BURST_W-1:0]  burst;
        logic [PRIO_W-1:0]   prio;
        logic [TS_W-1:0]     stamp;
    } sched_req_t;

    typedef struct packed {
        logic [ID_W-1:0]     ident;
        logic [PRIO_W-1:0]   prio;
        logic [BURST_W-1:0]  total;
        logic [TS_W-1:0]     arrival;
        logic [BURST_W-1:0]  remaining;
    } ready_slot_t;

    typedef struct packed {
        logic                idle;
        ready_slot_t         slot;
        logic [TS_W-1:0]     start;
        logic [END_W-1:0]    stop_at;
        logic                rejected;
        logic [4:0]          count;
    } sched_res_t;

    class sched_scoreboard;
        bit                busy;
        ready_slot_t       cur;
        logic [TS_W-1:0]   cur_start;
        logic [END_W-1:0]  cur_stop;
        ready_slot_t       waiting_slots[QUEUE_SLOTS];
        int                waiting_cnt;
        sched_res_t        due_states[$];
        int                errors;

        function void dispatch(ready_slot_t s, logic [TS_W-1:0] stamp);
            busy      = 1'b1;
            cur       = s;
            cur_start = stamp;
            cur_stop  = END_W'(stamp) + END_W'(s.remaining);
        endfunction

        function void enqueue(ready_slot_t s);
            waiting_slots[waiting_cnt] = s;
            waiting_cnt++;
        endfunction

        function void note_beat(sched_req_t r);
            ready_slot_t       incoming;
            ready_slot_t       pick;
            logic [END_W-1:0]  left;
            sched_res_t        res;
            int                best;
            int                i;
            bit                drop;
            drop               = 1'b0;
            incoming.ident     = r.ident;
            incoming.prio      = r.prio;
            incoming.total     = r.burst;
            incoming.arrival   = r.arrival;
            incoming.remaining = r.burst;
            if (r.kind == KIND_ARRIVAL)
            begin
                if (!busy)
                    dispatch(incoming, r.stamp);
                else if (waiting_cnt == QUEUE_SLOTS)
                    drop = 1'b1;
                else if (r.prio >= cur.prio)
                    enqueue(incoming);
                else
                begin
                    // preempted process keeps what is left of its slice
                    if (cur_stop <= END_W'(r.stamp))
                        left = '0;
                    else
                        left = cur_stop - END_W'(r.stamp);
                    pick = cur;
                    pick.remaining = (left > END_W'(16'hFFFF)) ? 16'hFFFF : left[BURST_W-1:0];
                    enqueue(pick);
                    dispatch(incoming, r.stamp);
                end
            end
            else if (waiting_cnt == 0)
            begin
                busy      = 1'b0;
                cur       = '0;
                cur_start = '0;
                cur_stop  = '0;
            end
            else
            begin
                // lowest priority number, first index on ties
                best = 0;
                for (i = 1; i < waiting_cnt; i++)
                    if (waiting_slots[i].prio < waiting_slots[best].prio)
                        best = i;
                pick = waiting_slots[best];
                waiting_slots[best] = waiting_slots[waiting_cnt - 1];
                waiting_cnt--;
                dispatch(pick, r.stamp);
            end
            res.idle     = !busy;
            res.slot     = cur;
            res.start    = cur_start;
            res.stop_at  = cur_stop;
            res.rejected = drop;
            res.count    = 5'(waiting_cnt);
            due_states.push_back(res);
        endfunction

        function void match_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(sched_res_t got);
            sched_res_t want;
            if (due_states.size() == 0)
            begin
                $error("result beat with no outstanding event");
                errors++;
                return;
            end
            want = due_states.pop_front();
            match_field("cpu_idle", 32'(want.idle), 32'(got.idle));
            match_field("run_ident", 32'(want.slot.ident), 32'(got.slot.ident));
            match_field("run_arrival", 32'(want.slot.arrival), 32'(got.slot.arrival));
            match_field("run_total", 32'(want.slot.total), 32'(got.slot.total));
            match_field("run_remaining", 32'(want.slot.remaining),
                        32'(got.slot.remaining));
            match_field("run_priority", 32'(want.slot.prio), 32'(got.slot.prio));
            match_field("run_start", 32'(want.start), 32'(got.start));
            match_field("run_end", 32'(want.stop_at), 32'(got.stop_at));
            match_field("rejected", 32'(want.rejected), 32'(got.rejected));
            match_field("waiting_count", 32'(want.count), 32'(got.count));
        endfunction

        function int pending();
            return due_states.size();
        endfunction
    endclass

    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                in_valid      = 1'b0;
    logic                in_stall;
    logic                kind          = 1'b0;
    logic [ID_W-1:0]     proc_ident    = '0;
    logic [TS_W-1:0]     proc_arrival  = '0;
    logic [BURST_W-1:0]  proc_burst    = '0;
    logic [PRIO_W-1:0]   proc_priority = '0;
    logic [TS_W-1:0]     now           = '0;
    logic                out_valid;
    logic                out_stall     = 1'b0;
    logic                cpu_idle;
    logic [ID_W-1:0]     run_ident;
    logic [TS_W-1:0]     run_arrival;
    logic [BURST_W-1:0]  run_total;
    logic [BURST_W-1:0]  run_remaining;
    logic [PRIO_W-1:0]   run_priority;
    logic [TS_W-1:0]     run_start;
    logic [END_W-1:0]    run_end;
    logic                rejected;
    logic [4:0]          waiting_count;

    sched_scoreboard     sb;
    bit                  hold_req   = 1'b0;
    int                  burst_left = 0;
    logic [TS_W-1:0]     sim_stamp  = '0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    preemptive_priority_scheduler #(
        .QUEUE_DEPTH   (QUEUE_SLOTS)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .kind          (kind),
        .proc_ident    (proc_ident),
        .proc_arrival  (proc_arrival),
        .proc_burst    (proc_burst),
        .proc_priority (proc_priority),
        .now           (now),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .cpu_idle      (cpu_idle),
        .run_ident     (run_ident),
        .run_arrival   (run_arrival),
        .run_total     (run_total),
        .run_remaining (run_remaining),
        .run_priority  (run_priority),
        .run_start     (run_start),
        .run_end       (run_end),
        .rejected      (rejected),
        .waiting_count (waiting_count)
    );

    function automatic sched_req_t mk_req(logic k, logic [ID_W-1:0] id,
                                          logic [TS_W-1:0] arr, logic [BURST_W-1:0] bst,
                                          logic [PRIO_W-1:0] pr, logic [TS_W-1:0] ts);
        sched_req_t r;
        r.kind    = k;
        r.ident   = id;
        r.arrival = arr;
        r.burst   = bst;
        r.prio    = pr;
        r.stamp   = ts;
        return r;
    endfunction

    function automatic sched_req_t random_req(int fill_pct, bit narrow);
        sched_req_t r;
        case ($urandom_range(0, 19))
            0:       sim_stamp = TS_W'($urandom);
            1:       ;
            default: sim_stamp = sim_stamp + TS_W'($urandom_range(1, 400));
        endcase
        r.kind    = ($urandom_range(0, 99) < fill_pct) ? KIND_ARRIVAL : KIND_COMPLETE;
        r.stamp   = sim_stamp;
        r.ident   = ID_W'($urandom);
        r.arrival = ($urandom_range(0, 3) == 0) ? TS_W'($urandom) : sim_stamp;
        case ($urandom_range(0, 9))
            0:       r.burst = '0;
            1:       r.burst = BURST_W'($urandom);
            2:       r.burst = '1;
            default: r.burst = BURST_W'($urandom_range(1, 600));
        endcase
        r.prio = narrow ? PRIO_W'($urandom_range(0, 3)) : PRIO_W'($urandom);
        return r;
    endfunction

    task automatic idle_cycles(int n);
        repeat (n)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
    endtask

    task automatic offer(sched_req_t r);
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) != 0)
                idle_cycles($urandom_range(1, 12));
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 90)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        @(negedge clk);
        in_valid      <= 1'b1;
        kind          <= r.kind;
        proc_ident    <= r.ident;
        proc_arrival  <= r.arrival;
        proc_burst    <= r.burst;
        proc_priority <= r.prio;
        now           <= r.stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    task automatic run_directed();
        int n;
        offer(mk_req(KIND_COMPLETE, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'hFF, 24'h000010));
        offer(mk_req(KIND_ARRIVAL, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 8'h80, 24'hFFFFFF));
        offer(mk_req(KIND_ARRIVAL, 16'h0001, 24'h00000A, 16'h000A, 8'hFF, 24'h00000A));
        offer(mk_req(KIND_ARRIVAL, 16'h0002, 24'h00000C, 16'h0014, 8'h80, 24'h00000C));
        // preempt with now before start, remaining saturates
        offer(mk_req(KIND_ARRIVAL, 16'h0003, 24'h000005, 16'h0064, 8'h40, 24'h000000));
        // preempt past the planned end, remaining clamps to zero
        offer(mk_req(KIND_ARRIVAL, 16'h0004, 24'h0001F4, 16'h0032, 8'h10, 24'h0001F4));
        offer(mk_req(KIND_ARRIVAL, 16'h0005, 24'h0001FE, 16'h0007, 8'h10, 24'h0001FE));
        offer(mk_req(KIND_ARRIVAL, 16'h0006, 24'h0001FF, 16'h0009, 8'h10, 24'h0001FF));
        for (n = 0; n < 10; n++)
            offer(mk_req(KIND_ARRIVAL, 16'h0100 + 16'(n), 24'h000200 + 24'(n), 16'(n),
                         8'hFF - 8'(n), 24'h000200 + 24'(n)));
        // full queue, both the plain queue and the preemption path
        offer(mk_req(KIND_ARRIVAL, 16'hAAAA, 24'h000300, 16'h0005, 8'hFE, 24'h000300));
        offer(mk_req(KIND_ARRIVAL, 16'h5555, 24'h000301, 16'h0005, 8'h00, 24'h000301));
        offer(mk_req(KIND_COMPLETE, 16'h0000, 24'h000000, 16'h0000, 8'h00, 24'h000400));
        offer(mk_req(KIND_COMPLETE, 16'h1234, 24'h123456, 16'h4321, 8'h77, 24'h000410));
        offer(mk_req(KIND_COMPLETE, 16'h0000, 24'h000000, 16'h0000, 8'h00, 24'hFFFFFF));
        offer(mk_req(KIND_ARRIVAL, 16'h0000, 24'h000000, 16'h0000, 8'h00, 24'h000000));
    endtask

    task automatic run_random(int total);
        int sent;
        int phase_left;
        int fill_pct;
        bit narrow;
        sent       = 0;
        phase_left = 0;
        fill_pct   = 55;
        narrow     = 1'b0;
        while (sent < total)
        begin
            if (phase_left == 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    drain();
                phase_left = $urandom_range(15, 60);
                case ($urandom_range(0, 2))
                    0:       fill_pct = 85;
                    1:       fill_pct = 20;
                    default: fill_pct = 55;
                endcase
                narrow = 1'($urandom_range(0, 1));
            end
            if (sent == total / 3)
                hold_req = 1'b1;
            if (sent == total / 2)
                drain();
            offer(random_req(fill_pct, narrow));
            phase_left--;
            sent++;
        end
    endtask

    always @(posedge clk)
    begin
        sched_res_t seen;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_beat(mk_req(kind, proc_ident, proc_arrival, proc_burst,
                                    proc_priority, now));
            if (out_valid && !out_stall)
            begin
                seen.idle           = cpu_idle;
                seen.slot.ident     = run_ident;
                seen.slot.prio      = run_priority;
                seen.slot.total     = run_total;
                seen.slot.arrival   = run_arrival;
                seen.slot.remaining = run_remaining;
                seen.start          = run_start;
                seen.stop_at        = run_end;
                seen.rejected       = rejected;
                seen.count          = waiting_count;
                sb.check_result(seen);
            end
        end
    end

    initial
    begin
        int          seg_left;
        int          mode;
        int          pct;
        int          phase;
        logic [15:0] mask;
        @(posedge rst_n);
        forever
        begin
            seg_left = $urandom_range(20, 200);
            mode     = $urandom_range(0, 3);
            pct      = $urandom_range(10, 70);
            mask     = 16'($urandom);
            phase    = 0;
            while (seg_left > 0)
            begin
                @(negedge clk);
                if (hold_req)
                begin
                    // long hold-off so the block backs up its input
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES - 1)
                    begin
                        @(negedge clk);
                        out_stall <= 1'b1;
                    end
                    hold_req = 1'b0;
                end
                else
                begin
                    case (mode)
                        1:       out_stall <= ($urandom_range(0, 99) < pct);
                        2:       out_stall <= mask[phase % 16];
                        default: out_stall <= 1'b0;
                    endcase
                end
                phase++;
                seg_left--;
            end
        end
    end

    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        sb = new;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        run_directed();
        run_random(RANDOM_BEATS);
        idle_cycles(1);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
